FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the checks of the row-stream multiplier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHK_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define CHK_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

FILE: rtl/core/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// shared constants, register codes and control structs of the row-stream
// matrix multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

   localparam int DEF_MAX_DIM   = 16;
   localparam int DEF_ELEM_BITS = 16;
   localparam int SUM_BITS      = 40;
   localparam int COL_BITS      = 4;
   localparam int CFG_BITS      = 5;
   localparam int CSR_IDX_BITS  = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_INNER_DIM = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_COLS  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_ROWS  = 2'd2;

   localparam logic [CFG_BITS-1:0] CFG_RESET_DIM = 5'd1;

   // word kinds
   localparam logic REQ_TYPE_B = 1'b0;
   localparam logic REQ_TYPE_A = 1'b1;

   // sequencer to accumulator bank
   typedef struct packed {
      logic advance;
      logic issue;
      logic issue_last;
      logic emit;
   } acc_ctl_type;

   // accumulator bank back to sequencer
   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
      logic s2_last;
   } acc_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/mrs_channels.sv
// ----------------------------------------------------------------------------
// mrs channels
// valid/ready channel interfaces for request, response and csr writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrs_req_if #(
   parameter int ELEM_BITS = mrs_pkg::DEF_ELEM_BITS
);
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic signed [ELEM_BITS-1:0] element_value;

   modport source (output valid, output req_type, output element_value, input ready);
   modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

interface mrs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mrs_pkg::SUM_BITS-1:0]  product_sum;
   logic        [mrs_pkg::COL_BITS-1:0]  out_col;
   logic                                 last_in_row;
   logic                                 last_in_matrix;

   modport source (output valid, output product_sum, output out_col, output last_in_row,
                   output last_in_matrix, input ready);
   modport sink   (input valid, input product_sum, input out_col, input last_in_row,
                   input last_in_matrix, output ready);
endinterface

interface mrs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mrs_pkg::CSR_IDX_BITS-1:0]    index;
   logic [mrs_pkg::CFG_BITS-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mrs_accum.sv
// ----------------------------------------------------------------------------
// mrs_accum
// column accumulator bank: memory read, multiply, add and write-back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrs_accum #(
   parameter int MAX_DIM   = mrs_pkg::DEF_MAX_DIM,
   parameter int ELEM_BITS = mrs_pkg::DEF_ELEM_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mrs_pkg::acc_ctl_type                ctl,
   input  logic [$clog2(MAX_DIM)-1:0]          issue_col,
   input  logic signed [ELEM_BITS-1:0]         a_elem,
   input  logic signed [ELEM_BITS-1:0]         b_elem,
   output mrs_pkg::acc_stat_type               stat,
   output logic [$clog2(MAX_DIM)-1:0]          sum_col,
   output logic signed [mrs_pkg::SUM_BITS-1:0] sum
);

   localparam int DW = $clog2(MAX_DIM);
   localparam int PW = 2 * ELEM_BITS;

   logic signed [mrs_pkg::SUM_BITS-1:0] acc_mem [0:MAX_DIM-1];
   logic [MAX_DIM-1:0]                  acc_vld_ff;

   logic                                s1_vld_ff;
   logic [DW-1:0]                       s1_col_ff;
   logic                                s1_last_ff;
   logic signed [mrs_pkg::SUM_BITS-1:0] acc_rd_ff;
   logic                                acc_hit_ff;

   logic                                s2_vld_ff;
   logic [DW-1:0]                       s2_col_ff;
   logic                                s2_last_ff;
   logic signed [PW-1:0]                prod_ff;
   logic signed [mrs_pkg::SUM_BITS-1:0] acc_op_ff;

   // wraps modulo 2^SUM_BITS
   assign sum     = acc_op_ff + mrs_pkg::SUM_BITS'(prod_ff);
   assign sum_col = s2_col_ff;
   assign stat    = '{s1_valid: s1_vld_ff, s2_valid: s2_vld_ff, s2_last: s2_last_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         acc_vld_ff <= '0;
      end else if (ctl.advance) begin
         s1_vld_ff <= ctl.issue;
         s2_vld_ff <= s1_vld_ff;
         // an emitted column reads as zero for the next row
         if (s2_vld_ff) begin
            acc_vld_ff[s2_col_ff] <= !ctl.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         if (ctl.issue) begin
            s1_col_ff  <= issue_col;
            s1_last_ff <= ctl.issue_last;
            acc_rd_ff  <= acc_mem[issue_col];
            acc_hit_ff <= acc_vld_ff[issue_col];
         end
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
         prod_ff    <= PW'(a_elem) * PW'(b_elem);
         acc_op_ff  <= acc_hit_ff ? acc_rd_ff : '0;
         if (s2_vld_ff && !ctl.emit) begin
            acc_mem[s2_col_ff] <= sum;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/matrix_multiply_row_stream.sv
// timing: a B word is stored in the cycle it is accepted; once an A word is accepted no
// other word is taken until its columns have drained (one column per cycle through the
// single multiplier while the output register can take a word, plus memory read and add
// stages), and a row-ending A word delivers its results after the memory read, product
// and output registers, one result per cycle unless stalled; B words: one per cycle when idle.
// reset: synchronous; clears positions, accumulators and sets all dimensions to 1.
// ----------------------------------------------------------------------------
// matrix_multiply_row_stream
// streaming C = A x B: B words fill a memory, A words accumulate row products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module matrix_multiply_row_stream #(
   parameter int MAX_DIM   = mrs_pkg::DEF_MAX_DIM,
   parameter int ELEM_BITS = mrs_pkg::DEF_ELEM_BITS
) (
   input logic       clock,
   input logic       reset,
   mrs_req_if.sink   req_chan,
   mrs_rsp_if.source rsp_chan,
   mrs_csr_if.sink   csr_chan
);

   localparam int DW    = $clog2(MAX_DIM);
   localparam int CW    = DW + 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = AW + 1;

   // ---------------------------------------------------------------- csr
   logic [mrs_pkg::CFG_BITS-1:0] inner_dim_ff;
   logic [mrs_pkg::CFG_BITS-1:0] out_cols_ff;
   logic [mrs_pkg::CFG_BITS-1:0] out_rows_ff;

   // no write is taken while reset is high
   assign csr_chan.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_dim_ff <= mrs_pkg::CFG_RESET_DIM;
         out_cols_ff  <= mrs_pkg::CFG_RESET_DIM;
         out_rows_ff  <= mrs_pkg::CFG_RESET_DIM;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            mrs_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_chan.data;
            mrs_pkg::CSR_OUT_COLS:  out_cols_ff  <= csr_chan.data;
            mrs_pkg::CSR_OUT_ROWS:  out_rows_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // zero acts as one, anything above MAX_DIM acts as MAX_DIM
   function automatic logic [CW-1:0] eff_dim(input logic [mrs_pkg::CFG_BITS-1:0] raw);
      logic [CW-1:0] res;
      if (raw == '0) begin
         res = CW'(1);
      end else if (32'(raw) > MAX_DIM) begin
         res = CW'(MAX_DIM);
      end else begin
         res = CW'(raw);
      end
      return res;
   endfunction

   logic [CW-1:0] dim_k;
   logic [CW-1:0] dim_n;
   logic [CW-1:0] dim_m;

   assign dim_k = eff_dim(inner_dim_ff);
   assign dim_n = eff_dim(out_cols_ff);
   assign dim_m = eff_dim(out_rows_ff);

   // ---------------------------------------------------------------- state
   logic [AW-1:0]                b_pos_ff,  b_pos_in;
   logic [DW-1:0]                a_col_ff,  a_col_in;
   logic [DW-1:0]                a_row_ff,  a_row_in;
   logic                         busy_ff,   busy_in;
   logic [DW-1:0]                cnt_ff,    cnt_in;
   logic [AW-1:0]                base_ff;
   logic signed [ELEM_BITS-1:0]  elem_ff;
   logic                         emit_ff;
   logic                         mat_row_last_ff;

   logic [ELEM_BITS-1:0]         b_mem [0:DEPTH-1];
   logic signed [ELEM_BITS-1:0]  b_rd_ff;

   // output register
   logic                                rsp_valid_ff;
   logic signed [mrs_pkg::SUM_BITS-1:0] rsp_sum_ff;
   logic [mrs_pkg::COL_BITS-1:0]        rsp_col_ff;
   logic                                rsp_last_row_ff;
   logic                                rsp_last_mat_ff;

   // ---------------------------------------------------------------- handshake
   logic                  req_ready;
   logic                  req_fire;
   logic                  fire_b;
   logic                  fire_a;
   logic                  adv;
   mrs_pkg::acc_stat_type stat;

   // one word at a time: accept only once the accumulate pipe has drained
   assign req_ready      = !reset && !busy_ff && !stat.s1_valid && !stat.s2_valid;
   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;
   assign fire_b         = req_fire && (req_chan.req_type == mrs_pkg::REQ_TYPE_B);
   assign fire_a         = req_fire && (req_chan.req_type == mrs_pkg::REQ_TYPE_A);

   // the whole pipe moves only when the output register can take a word
   assign adv = !rsp_valid_ff || rsp_chan.ready;

   // ---------------------------------------------------------------- positions
   logic [TW-1:0] b_total;
   logic [AW-1:0] b_pos_eff;
   logic [TW-1:0] b_pos_inc;
   logic [DW-1:0] a_col_eff;
   logic [DW-1:0] a_row_eff;
   logic          row_done;
   logic          row_last;
   logic [AW-1:0] base_in;

   always_comb begin
      b_total   = TW'(TW'(dim_k) * TW'(dim_n));
      // positions past a shrunken bound restart at zero
      b_pos_eff = (TW'(b_pos_ff) >= b_total) ? '0 : b_pos_ff;
      b_pos_inc = TW'(b_pos_eff) + TW'(1);
      a_col_eff = (CW'(a_col_ff) >= dim_k) ? '0 : a_col_ff;
      a_row_eff = (CW'(a_row_ff) >= dim_m) ? '0 : a_row_ff;
      row_done  = (CW'(a_col_eff) == (dim_k - CW'(1)));
      row_last  = (CW'(a_row_eff) == (dim_m - CW'(1)));
      // start of B row k in the row-major store
      base_in   = AW'(TW'(a_col_eff) * TW'(dim_n));

      b_pos_in = b_pos_ff;
      a_col_in = a_col_ff;
      a_row_in = a_row_ff;
      if (fire_b) begin
         b_pos_in = (b_pos_inc >= b_total) ? '0 : AW'(b_pos_inc);
      end
      if (fire_a) begin
         a_col_in = row_done ? '0 : (a_col_eff + DW'(1));
         if (row_done) begin
            a_row_in = row_last ? '0 : (a_row_eff + DW'(1));
         end else begin
            a_row_in = a_row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_pos_ff <= '0;
         a_col_ff <= '0;
         a_row_ff <= '0;
      end else begin
         b_pos_ff <= b_pos_in;
         a_col_ff <= a_col_in;
         a_row_ff <= a_row_in;
      end
   end

   // ---------------------------------------------------------------- column sequencer
   logic issue;
   logic issue_last;

   // one column of the B row per cycle while the output register can take a word
   assign issue      = busy_ff && adv;
   assign issue_last = (CW'(cnt_ff) == (dim_n - CW'(1)));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (fire_a) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (issue) begin
         if (issue_last) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // per-word context, held for the whole word
   always_ff @(posedge clock) begin
      if (fire_a) begin
         base_ff         <= base_in;
         elem_ff         <= req_chan.element_value;
         emit_ff         <= row_done;
         mat_row_last_ff <= row_last;
      end
   end

   // ---------------------------------------------------------------- B memory
   // one write port for loading, one registered read port for the sequencer
   always_ff @(posedge clock) begin
      if (fire_b) begin
         b_mem[b_pos_eff] <= req_chan.element_value;
      end
      if (issue) begin
         b_rd_ff <= b_mem[base_ff + AW'(cnt_ff)];
      end
   end

   // ---------------------------------------------------------------- accumulators
   mrs_pkg::acc_ctl_type                acc_ctl;
   logic [DW-1:0]                       sum_col;
   logic signed [mrs_pkg::SUM_BITS-1:0] sum;

   assign acc_ctl = '{advance: adv, issue: issue, issue_last: issue_last, emit: emit_ff};

   mrs_accum #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctl       (acc_ctl),
      .issue_col (cnt_ff),
      .a_elem    (elem_ff),
      .b_elem    (b_rd_ff),
      .stat      (stat),
      .sum_col   (sum_col),
      .sum       (sum)
   );

   // ---------------------------------------------------------------- output register
   logic rsp_load;

   // a row-ending word sends each finished column out instead of writing it back
   assign rsp_load = adv && stat.s2_valid && emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= stat.s2_valid && emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sum_ff      <= sum;
         rsp_col_ff      <= mrs_pkg::COL_BITS'(sum_col);
         rsp_last_row_ff <= stat.s2_last;
         rsp_last_mat_ff <= stat.s2_last && mat_row_last_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.product_sum    = rsp_sum_ff;
   assign rsp_chan.out_col        = rsp_col_ff;
   assign rsp_chan.last_in_row    = rsp_last_row_ff;
   assign rsp_chan.last_in_matrix = rsp_last_mat_ff;

   // ---------------------------------------------------------------- checks
   `CHK_IMPLY(a_mat_end_on_row_end, clock, reset, rsp_valid_ff && rsp_last_mat_ff, rsp_last_row_ff)
   `CHK_IMPLY(a_row_end_col, clock, reset, rsp_valid_ff && rsp_last_row_ff,
              rsp_col_ff == mrs_pkg::COL_BITS'(dim_n - CW'(1)))
   `CHK_NEXT(a_emit_reaches_output, clock, reset, rsp_load, rsp_valid_ff)
   `CHK_NEXT(a_stall_holds_issue, clock, reset, busy_ff && !adv, busy_ff && $stable(cnt_ff))

endmodule

`default_nettype wire
